// ===== src/jsh_pkg.sv =====
package jsh_pkg;

   // sample and datapath widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int GUARD_BITS   = 8;
   localparam int XY_W         = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int Z_W          = 26;
   localparam int ANG_W        = Z_W - 1;
   localparam int GAIN_W       = 16;
   localparam int PROD_W       = XY_W - 1 + GAIN_W;
   localparam int SPEED_W      = 16;
   localparam int HEADING_W    = 15;
   localparam int DEADBAND_W   = 15;

   // arithmetic constants
   localparam logic [GAIN_W-1:0]        INV_GAIN     = 16'd39797;
   localparam logic signed [Z_W-1:0]    DEG_90       = 26'sd5898240;
   localparam logic signed [Z_W:0]      DEG_360      = 27'sd23592960;
   localparam logic [SPEED_W:0]         HEADING_WRAP = 17'd23040;
   localparam int                       SPEED_SHIFT  = GUARD_BITS + 16;
   localparam logic [PROD_W:0]          SPEED_ROUND  = (PROD_W + 1)'(1) << (GUARD_BITS + 15);
   localparam logic [ANG_W:0]           HEADING_ROUND = (ANG_W + 1)'(512);
   localparam int                       HEADING_SHIFT = 10;

   // control registers
   localparam int                       CSR_ADDR_W     = 3;
   localparam int                       CSR_DATA_W     = 32;
   localparam logic                     REG_DEADBAND   = 1'b0;
   localparam logic [DEADBAND_W-1:0]    DEADBAND_RESET = 15'd328;

   // one sample as it moves down the rotation chain
   typedef struct packed {
      logic signed [XY_W-1:0]         x;
      logic signed [XY_W-1:0]         y;
      logic signed [Z_W-1:0]          z;
      logic                           zero;
      logic signed [SAMPLE_WIDTH-1:0] twist;
   } cordic_type;

   // atan(2^-step) in degrees * 2^16, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_step(input int step);
      logic signed [Z_W-1:0] a;
      case (step)
         0:       a = 26'sd2949120;
         1:       a = 26'sd1740967;
         2:       a = 26'sd919879;
         3:       a = 26'sd466945;
         4:       a = 26'sd234379;
         5:       a = 26'sd117304;
         6:       a = 26'sd58666;
         7:       a = 26'sd29335;
         8:       a = 26'sd14668;
         9:       a = 26'sd7334;
         10:      a = 26'sd3667;
         11:      a = 26'sd1833;
         12:      a = 26'sd917;
         13:      a = 26'sd458;
         14:      a = 26'sd229;
         15:      a = 26'sd115;
         16:      a = 26'sd57;
         17:      a = 26'sd29;
         18:      a = 26'sd14;
         19:      a = 26'sd7;
         20:      a = 26'sd4;
         21:      a = 26'sd2;
         22:      a = 26'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/jsh_front.sv =====
module jsh_front
   import jsh_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] stick_x,
   input  logic signed [SAMPLE_WIDTH-1:0] stick_y_raw,
   input  logic signed [SAMPLE_WIDTH-1:0] stick_twist,
   output logic                           out_valid,
   output cordic_type                     out_data
);

   localparam logic signed [SAMPLE_WIDTH:0] SMAX =
      (SAMPLE_WIDTH + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);

   logic                           valid_ff;
   cordic_type                     data_ff;
   cordic_type                     data_in;
   logic signed [SAMPLE_WIDTH:0]   y_neg;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;
   logic signed [XY_W-1:0]         x_g;
   logic signed [XY_W-1:0]         y_g;

   // flip y so forward is positive, saturating the one overflow case
   always_comb begin
      y_neg = -((SAMPLE_WIDTH + 1)'(stick_y_raw));
      if (y_neg > SMAX) begin
         y_sat = SMAX[SAMPLE_WIDTH-1:0];
      end else begin
         y_sat = y_neg[SAMPLE_WIDTH-1:0];
      end
      x_g = $signed({{(XY_W - SAMPLE_WIDTH - GUARD_BITS){stick_x[SAMPLE_WIDTH-1]}},
                     stick_x, {GUARD_BITS{1'b0}}});
      y_g = $signed({{(XY_W - SAMPLE_WIDTH - GUARD_BITS){y_sat[SAMPLE_WIDTH-1]}},
                     y_sat, {GUARD_BITS{1'b0}}});
   end

   // quarter turn into the right half plane
   always_comb begin
      data_in.zero  = (stick_x == '0) && (y_sat == '0);
      data_in.twist = stick_twist;
      data_in.x     = x_g;
      data_in.y     = y_g;
      data_in.z     = '0;
      if (x_g < 0) begin
         if (y_g >= 0) begin
            data_in.x = y_g;
            data_in.y = -x_g;
            data_in.z = DEG_90;
         end else begin
            data_in.x = -y_g;
            data_in.y = x_g;
            data_in.z = -DEG_90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/jsh_cell.sv =====
module jsh_cell
   import jsh_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       in_valid,
   input  cordic_type in_data,
   output logic       out_valid,
   output cordic_type out_data
);

   localparam logic signed [Z_W-1:0] ATAN = atan_step(STEP);

   logic                   valid_ff;
   cordic_type             data_ff;
   cordic_type             data_in;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;

   // one micro-rotation, direction set by the sign of y
   always_comb begin
      xs      = in_data.x >>> STEP;
      ys      = in_data.y >>> STEP;
      data_in = in_data;
      if (in_data.y > 0) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN;
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/jsh_back.sv =====
module jsh_back
   import jsh_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  cordic_type                     in_data,
   input  logic [DEADBAND_W-1:0]          deadband,
   output logic                           out_valid,
   output logic [SPEED_W-1:0]             drive_speed,
   output logic [HEADING_W-1:0]           drive_heading,
   output logic signed [SAMPLE_WIDTH-1:0] drive_rotation
);

   localparam int SPD_FULL_W = PROD_W + 1 - SPEED_SHIFT;
   localparam int HDG_FULL_W = ANG_W + 1 - HEADING_SHIFT;

   // gain stage
   logic                           mul_valid_ff;
   logic [PROD_W-1:0]              prod_ff;
   logic [PROD_W-1:0]              prod_in;
   logic [ANG_W-1:0]               angle_ff;
   logic [ANG_W-1:0]               angle_in;
   logic signed [SAMPLE_WIDTH-1:0] twist_ff;
   logic [XY_W-2:0]                x_pos;
   logic signed [Z_W-1:0]          z_sel;
   logic signed [Z_W:0]            t_raw;
   logic signed [Z_W:0]            t_wrap;

   // output stage
   logic                           rsp_valid_ff;
   logic [SPEED_W-1:0]             speed_ff;
   logic [SPEED_W-1:0]             speed_in;
   logic [HEADING_W-1:0]           heading_ff;
   logic [HEADING_W-1:0]           heading_in;
   logic signed [SAMPLE_WIDTH-1:0] rotation_ff;
   logic [PROD_W:0]                speed_sum;
   logic [SPD_FULL_W-1:0]          speed_full;
   logic [ANG_W:0]                 heading_sum;
   logic [HDG_FULL_W-1:0]          heading_full;
   logic [HDG_FULL_W-1:0]          heading_wrapped;

   // magnitude scaling and compass angle
   always_comb begin
      x_pos   = in_data.x[XY_W-1] ? '0 : in_data.x[XY_W-2:0];
      prod_in = PROD_W'(x_pos) * PROD_W'(INV_GAIN);
      z_sel   = in_data.zero ? '0 : in_data.z;
      t_raw   = (Z_W + 1)'(DEG_90) - (Z_W + 1)'(z_sel);
      t_wrap  = (t_raw < 0) ? t_raw + DEG_360 : t_raw;
      angle_in = t_wrap[ANG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         angle_ff <= angle_in;
         twist_ff <= in_data.twist;
      end
   end

   // rounding, saturation, wrap and deadband
   always_comb begin
      speed_sum  = (PROD_W + 1)'(prod_ff) + SPEED_ROUND;
      speed_full = speed_sum[PROD_W:SPEED_SHIFT];
      if (|speed_full[SPD_FULL_W-1:SPEED_W]) begin
         speed_in = '1;
      end else begin
         speed_in = speed_full[SPEED_W-1:0];
      end
      heading_sum  = (ANG_W + 1)'(angle_ff) + HEADING_ROUND;
      heading_full = heading_sum[ANG_W:HEADING_SHIFT];
      if ((SPEED_W + 1)'(heading_full) >= HEADING_WRAP) begin
         heading_wrapped = heading_full - HDG_FULL_W'(HEADING_WRAP);
      end else begin
         heading_wrapped = heading_full;
      end
      if (speed_in < SPEED_W'(deadband)) begin
         heading_in = '0;
      end else begin
         heading_in = heading_wrapped[HEADING_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         speed_ff    <= speed_in;
         heading_ff  <= heading_in;
         rotation_ff <= twist_ff;
      end
   end

   assign out_valid      = rsp_valid_ff;
   assign drive_speed    = speed_ff;
   assign drive_heading  = heading_ff;
   assign drive_rotation = rotation_ff;

endmodule

// ===== src/joystick_to_heading_and_speed.sv =====
// Joystick to heading and speed: each request carries one stick sample (x, raw y,
// twist, Q1.15) and yields one response with the stick magnitude, the compass
// heading clockwise from forward in degrees * 64 (0 when the magnitude is below the
// deadband register) and the twist unchanged. A new request is taken every cycle
// while the response side keeps up; the pipeline is an input stage that flips y
// and folds the vector into the right half plane, one CORDIC cell per rotation
// step, a gain-multiply stage and the response register. When a response is held
// back the whole pipeline stalls. The deadband register sits at byte addresses 0
// to 3 of the control port (only the top address bit is decoded); it resets to 328.
module joystick_to_heading_and_speed
   import jsh_pkg::*;
#(
   parameter int ROTATION_STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_stick_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_stick_y_raw,
   input  logic signed [SAMPLE_WIDTH-1:0] req_stick_twist,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [SPEED_W-1:0]             rsp_drive_speed,
   output logic [HEADING_W-1:0]           rsp_drive_heading,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_drive_rotation,
   // control port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [CSR_DATA_W-1:0]          csr_pwdata,
   output logic [CSR_DATA_W-1:0]          csr_prdata,
   output logic                           csr_pready
);

   logic                  advance;
   logic                  chain_valid [0:ROTATION_STEPS];
   cordic_type            chain_data  [0:ROTATION_STEPS];
   logic [DEADBAND_W-1:0] deadband_ff;
   logic                  csr_write;

   // pipeline moves whenever the response register is free or being drained
   // no request is taken while in reset
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && !reset;

   // deadband register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RESET;
      end else if (csr_write && (csr_paddr[CSR_ADDR_W-1] == REG_DEADBAND)) begin
         deadband_ff <= csr_pwdata[DEADBAND_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[CSR_ADDR_W-1] == REG_DEADBAND) begin
         csr_prdata = CSR_DATA_W'(deadband_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // input stage
   jsh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .stick_x     (req_stick_x),
      .stick_y_raw (req_stick_y_raw),
      .stick_twist (req_stick_twist),
      .out_valid   (chain_valid[0]),
      .out_data    (chain_data[0])
   );

   // rotation chain
   for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
      jsh_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // gain, heading and response register
   jsh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (chain_valid[ROTATION_STEPS]),
      .in_data        (chain_data[ROTATION_STEPS]),
      .deadband       (deadband_ff),
      .out_valid      (rsp_valid),
      .drive_speed    (rsp_drive_speed),
      .drive_heading  (rsp_drive_heading),
      .drive_rotation (rsp_drive_rotation)
   );

endmodule
